// ----- rtl/cct_pkg.sv -----
// Shared constants and types of the color count mode tracker.
package cct_pkg;

   localparam int COLORS_DEFAULT     = 1024;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int CMD_BITS       = 2;
   localparam int COLOR_BITS     = 10;
   localparam int EDGE_BITS      = 16;
   localparam int TOP_COUNT_BITS = 16;

   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEAF,
      ST_PULL,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/cct_req_if.sv -----
// Request channel: command, color and path length with valid/ready.
interface cct_req_if;
   import cct_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [COLOR_BITS-1:0] color;
   logic [EDGE_BITS-1:0]  path_edges;

   modport source (output valid, output command, output color, output path_edges,
                   input ready);
   modport sink   (input valid, input command, input color, input path_edges,
                   output ready);
endinterface

// ----- rtl/cct_rsp_if.sv -----
// Response channel: top color, its count and the majority flag with valid/ready.
interface cct_rsp_if;
   import cct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COLOR_BITS-1:0]     top_color;
   logic [TOP_COUNT_BITS-1:0] top_count;
   logic                      is_dominant;

   modport source (output valid, output top_color, output top_count, output is_dominant,
                   input ready);
   modport sink   (input valid, input top_color, input top_count, input is_dominant,
                   output ready);
endinterface

// ----- rtl/cct_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module cct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

// ----- rtl/color_count_mode_tracker.sv -----
// Top level: per-color counter with a running mode kept in a tournament tree in RAM.
//
// Usage: items enter on req_chan (command, color, path_edges) and every item
// returns exactly one item on rsp_chan (top_color, top_count, is_dominant).
// Add and remove items walk the tree from the leaf of the color to the root,
// one read-modify-write of the tree RAM per level: an update passes ST_LEAF,
// then one ST_PULL per level, then ST_OUT, which loads the result register.
// A query, any other command, or an update of a color out of range, reads the
// root only in ST_ROOT and loads it in ST_OUT. One item is in work at a time;
// req_chan.ready is high while the sequencer is idle, which it reenters as the
// result register loads, so a new item is taken only after the last result has
// loaded. At reset the block runs a clearing pass over the tree RAM that writes
// every node, with req_chan.ready low. Afterwards the top color is COLORS-1
// with count zero. The result waits in an output register while the receiver
// stalls; the next item is accepted meanwhile and its result holds in the
// sequencer until the output register frees.
module color_count_mode_tracker #(
   parameter int COLORS     = cct_pkg::COLORS_DEFAULT,
   parameter int COUNT_BITS = cct_pkg::COUNT_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   cct_req_if.sink   req_chan,
   cct_rsp_if.source rsp_chan
);
   import cct_pkg::*;

   localparam int LEAF_BITS  = $clog2(COLORS);
   localparam int LEAVES     = 1 << LEAF_BITS;
   localparam int ADDR_BITS  = LEAF_BITS + 1;
   localparam int DEPTH      = 2 * LEAVES;
   localparam int ENTRY_BITS = COUNT_BITS + LEAF_BITS;
   localparam int CMP_BITS   = (COUNT_BITS > EDGE_BITS + 1) ? COUNT_BITS : EDGE_BITS + 1;
   localparam int CW         = (LEAF_BITS > COLOR_BITS) ? LEAF_BITS : COLOR_BITS;

   localparam logic [LEAF_BITS-1:0] TOP_LEAF  = LEAF_BITS'(COLORS - 1);
   localparam logic [ADDR_BITS-1:0] ROOT_ADDR = ADDR_BITS'(1);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [ADDR_BITS-1:0]      node_ff, node_in;
   logic [COUNT_BITS-1:0]     cur_cnt_ff, cur_cnt_in;
   logic [LEAF_BITS-1:0]      cur_col_ff, cur_col_in;
   logic [EDGE_BITS-1:0]      edges_ff, edges_in;
   logic                      add_ff, add_in;
   logic [ADDR_BITS-1:0]      clr_addr_ff, clr_addr_in;
   logic [LEAF_BITS-1:0]      clr_col_ff, clr_col_in;
   logic [ADDR_BITS-1:0]      clr_step_ff, clr_step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COLOR_BITS-1:0]     rsp_color_ff, rsp_color_in;
   logic [TOP_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                      rsp_dom_ff, rsp_dom_in;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [ENTRY_BITS-1:0] ram_rdata;

   logic [COUNT_BITS-1:0] rd_cnt, leaf_cnt, left_cnt, right_cnt, win_cnt;
   logic [LEAF_BITS-1:0]  rd_col, left_col, right_col, win_col, clr_col_sat;
   logic [ADDR_BITS-1:0]  leaf_addr, parent_addr;
   logic                  is_update, accept, level_end;
   logic [CMP_BITS-1:0]   best_w, half_w;
   logic [CW-1:0]         color_w;

   cct_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_tree (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   assign rd_cnt = ram_rdata[ENTRY_BITS-1 -: COUNT_BITS];
   assign rd_col = ram_rdata[LEAF_BITS-1:0];

   assign is_update = ((req_chan.command == CMD_ADD) || (req_chan.command == CMD_REMOVE))
                      && (32'(req_chan.color) < 32'(COLORS));
   assign accept    = req_chan.valid && req_chan.ready;
   assign leaf_addr = {1'b1, LEAF_BITS'(req_chan.color)};

   // saturate at both ends
   always_comb begin
      if (add_ff) begin
         leaf_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
      end else begin
         leaf_cnt = (rd_cnt == '0) ? rd_cnt : rd_cnt - COUNT_BITS'(1);
      end
   end

   // cur_ff holds the child just written; the sibling comes from the RAM
   assign left_cnt    = node_ff[0] ? rd_cnt : cur_cnt_ff;
   assign left_col    = node_ff[0] ? rd_col : cur_col_ff;
   assign right_cnt   = node_ff[0] ? cur_cnt_ff : rd_cnt;
   assign right_col   = node_ff[0] ? cur_col_ff : rd_col;
   assign win_cnt     = (left_cnt > right_cnt) ? left_cnt : right_cnt;
   assign win_col     = (left_cnt > right_cnt) ? left_col : right_col;
   assign parent_addr = node_ff >> 1;

   // clearing pass: a node starts out owned by the rightmost real color of its range, or by COLORS-1 if none
   assign clr_col_sat = (clr_col_ff > TOP_LEAF) ? TOP_LEAF : clr_col_ff;
   assign level_end   = ({1'b0, clr_col_ff} == clr_step_ff - ADDR_BITS'(1));

   assign best_w  = CMP_BITS'(cur_cnt_ff);
   assign half_w  = CMP_BITS'(({1'b0, edges_ff} + (EDGE_BITS + 1)'(1)) >> 1);
   assign color_w = CW'(cur_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= LAST_ADDR;
         clr_col_ff   <= '1;
         clr_step_ff  <= ADDR_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_col_ff   <= clr_col_in;
         clr_step_ff  <= clr_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      cur_cnt_ff   <= cur_cnt_in;
      cur_col_ff   <= cur_col_in;
      edges_ff     <= edges_in;
      add_ff       <= add_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
      rsp_dom_ff   <= rsp_dom_in;
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      cur_cnt_in   = cur_cnt_ff;
      cur_col_in   = cur_col_ff;
      edges_in     = edges_ff;
      add_in       = add_ff;
      clr_addr_in  = clr_addr_ff;
      clr_col_in   = clr_col_ff;
      clr_step_in  = clr_step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in = rsp_color_ff;
      rsp_count_in = rsp_count_ff;
      rsp_dom_in   = rsp_dom_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = {cur_cnt_ff, cur_col_ff};
      ram_raddr    = node_ff ^ ADDR_BITS'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = {COUNT_BITS'(0), clr_col_sat};
            if (clr_addr_ff == ROOT_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff - ADDR_BITS'(1);
               if (level_end) begin
                  clr_col_in  = '1;
                  clr_step_in = clr_step_ff << 1;
               end else begin
                  clr_col_in = clr_col_ff - clr_step_ff[LEAF_BITS-1:0];
               end
            end
         end
         ST_IDLE: begin
            ram_raddr = is_update ? leaf_addr : ROOT_ADDR;
            if (accept) begin
               edges_in = req_chan.path_edges;
               add_in   = (req_chan.command == CMD_ADD);
               node_in  = leaf_addr;
               state_in = is_update ? ST_LEAF : ST_ROOT;
            end
         end
         ST_LEAF: begin
            ram_we     = 1'b1;
            ram_waddr  = node_ff;
            ram_wdata  = {leaf_cnt, rd_col};
            cur_cnt_in = leaf_cnt;
            cur_col_in = rd_col;
            ram_raddr  = node_ff ^ ADDR_BITS'(1);
            state_in   = ST_PULL;
         end
         ST_PULL: begin
            ram_we     = 1'b1;
            ram_waddr  = parent_addr;
            ram_wdata  = {win_cnt, win_col};
            cur_cnt_in = win_cnt;
            cur_col_in = win_col;
            node_in    = parent_addr;
            ram_raddr  = parent_addr ^ ADDR_BITS'(1);
            if (parent_addr == ROOT_ADDR) begin
               state_in = ST_OUT;
            end
         end
         ST_ROOT: begin
            cur_cnt_in = rd_cnt;
            cur_col_in = rd_col;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = color_w[COLOR_BITS-1:0];
               rsp_count_in = (best_w > CMP_BITS'({TOP_COUNT_BITS{1'b1}})) ?
                              '1 : best_w[TOP_COUNT_BITS-1:0];
               rsp_dom_in   = (best_w > half_w);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.top_color   = rsp_color_ff;
   assign rsp_chan.top_count   = rsp_count_ff;
   assign rsp_chan.is_dominant = rsp_dom_ff;
endmodule

// ----- rtl/cct_checker.sv -----
// Port-level checks of the color count mode tracker and their binding.
module cct_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [cct_pkg::COLOR_BITS-1:0]     top_color,
   input logic [cct_pkg::TOP_COUNT_BITS-1:0] top_count,
   input logic                               is_dominant
);
   import cct_pkg::*;

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(top_color) && $stable(top_count)
                                  && $stable(is_dominant))
      else $error("stalled response changed");

   // reset starts the clearing pass: no item taken, no response shown
   assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   // a majority needs at least one occurrence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_dominant |-> top_count != '0)
      else $error("majority flagged with zero count");
endmodule

bind color_count_mode_tracker cct_checker u_cct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .top_color   (rsp_chan.top_color),
   .top_count   (rsp_chan.top_count),
   .is_dominant (rsp_chan.is_dominant)
);
